/* hdl/tsa_pkg.sv */
// Package: shared constants, types and codes of the transport-stream sync aligner.
package tsa_pkg;

	// Packet geometry
	localparam int PACKET_LEN    = 188;
	localparam int CONFIRM_COUNT = 3;
	localparam int HIST_LEN      = PACKET_LEN * CONFIRM_COUNT;
	localparam int PHASE_W       = $clog2(PACKET_LEN);
	localparam int POS_W         = 16;
	localparam int BYTE_W        = 8;

	localparam logic [POS_W-1:0]   POS_MAX    = {POS_W{1'b1}};
	localparam logic [POS_W-1:0]   HIST_LEN_P = POS_W'(HIST_LEN);
	localparam logic [POS_W-1:0]   PKT_LAST_P = POS_W'(PACKET_LEN - 1);
	localparam logic [POS_W-1:0]   PKT_LEN_P  = POS_W'(PACKET_LEN);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PACKET_LEN - 1);

	// Result slots of one input byte, in delivery order
	localparam int NSLOTS    = CONFIRM_COUNT + 3;
	localparam int SLOT_W    = $clog2(NSLOTS);
	localparam int SLOT_HEAD = 0;
	localparam int SLOT_PKT0 = 1;
	localparam int SLOT_CMP  = CONFIRM_COUNT + 1;
	localparam int SLOT_END  = CONFIRM_COUNT + 2;

	// Descriptor queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Reset value of the sync byte register
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h47;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_HEAD   = 2'd0,
		KIND_PACKET = 2'd1,
		KIND_TAIL   = 2'd2,
		KIND_NOSYNC = 2'd3
	} kind_t;

	// Everything the back end needs to expand one byte into its results
	typedef struct packed {
		logic [NSLOTS-1:0] slots;
		logic              lock_sat;
		logic [POS_W-1:0]  lock_start;
		logic [POS_W-1:0]  cmp_off;
		kind_t             end_kind;
		logic [POS_W-1:0]  end_off;
		logic [POS_W-1:0]  end_len;
	} tsa_desc_t;

endpackage

/* hdl/tsa_front.sv */
// Front end: byte intake, sync search, lock tracking and descriptor build.
module tsa_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tsa_pkg::BYTE_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [tsa_pkg::BYTE_W-1:0] s_tdata,
	input  logic                      s_tlast,
	input  logic                      q_full,
	output logic                      q_push,
	output tsa_pkg::tsa_desc_t        q_desc
);

	logic [tsa_pkg::BYTE_W-1:0]   sync_q;
	logic [tsa_pkg::POS_W-1:0]    pos_q;
	logic                         locked_q;
	logic [tsa_pkg::PHASE_W-1:0]  phase_q;
	logic [tsa_pkg::HIST_LEN-1:0] hist_q;

	logic                         acc;
	logic                         cur;
	logic                         sat;
	logic                         confirm;
	logic                         at_zero;
	logic                         found;
	logic                         lock_new;
	logic                         cmp;
	logic [tsa_pkg::POS_W-1:0]    start;
	logic [tsa_pkg::POS_W-1:0]    bp;
	logic [tsa_pkg::PHASE_W-1:0]  phase_new;
	logic [tsa_pkg::POS_W-1:0]    phase_ext;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	// Classify the incoming word against the history taps
	always_comb begin
		cur     = (s_tdata == sync_q);
		sat     = (pos_q == tsa_pkg::POS_MAX);
		at_zero = (pos_q == '0) && cur;
		confirm = cur;
		for (int j = 0; j < tsa_pkg::CONFIRM_COUNT; j++) begin
			confirm = confirm && hist_q[(tsa_pkg::CONFIRM_COUNT - j) * tsa_pkg::PACKET_LEN - 1];
		end
		found = !locked_q &&
			(at_zero || (confirm && (sat || pos_q >= tsa_pkg::HIST_LEN_P)));
		if (at_zero) begin
			start = '0;
		end else if (sat) begin
			start = tsa_pkg::POS_MAX;
		end else begin
			start = pos_q - tsa_pkg::HIST_LEN_P;
		end
		lock_new = locked_q || found;
		cmp      = locked_q && (phase_q >= tsa_pkg::PHASE_LAST);

		// Advance the phase within the packet
		if (found) begin
			phase_new = tsa_pkg::PHASE_W'(1);
		end else if (locked_q) begin
			phase_new = cmp ? '0 : phase_q + tsa_pkg::PHASE_W'(1);
		end else begin
			phase_new = phase_q;
		end
		phase_ext = tsa_pkg::POS_W'(phase_new);
		bp        = sat ? tsa_pkg::POS_MAX : pos_q + tsa_pkg::POS_W'(1);
	end

	// Build the descriptor
	always_comb begin
		q_desc.slots = '0;
		q_desc.slots[tsa_pkg::SLOT_HEAD] = found;
		for (int j = 0; j < tsa_pkg::CONFIRM_COUNT; j++) begin
			q_desc.slots[tsa_pkg::SLOT_PKT0 + j] = found;
		end
		q_desc.slots[tsa_pkg::SLOT_CMP] = cmp;
		q_desc.slots[tsa_pkg::SLOT_END] = s_tlast;
		q_desc.lock_sat   = sat;
		q_desc.lock_start = start;
		q_desc.cmp_off    = (sat || pos_q < tsa_pkg::PKT_LAST_P) ?
			tsa_pkg::POS_MAX : pos_q - tsa_pkg::PKT_LAST_P;
		if (lock_new) begin
			q_desc.end_kind = tsa_pkg::KIND_TAIL;
			q_desc.end_off  = (bp == tsa_pkg::POS_MAX || bp < phase_ext) ?
				tsa_pkg::POS_MAX : bp - phase_ext;
			q_desc.end_len  = phase_ext;
		end else begin
			q_desc.end_kind = tsa_pkg::KIND_NOSYNC;
			q_desc.end_off  = bp;
			q_desc.end_len  = bp;
		end
	end

	assign q_push = acc && (|q_desc.slots);

	// Hold the sync byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= tsa_pkg::SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// Advance stream state; drop it all at buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			locked_q <= 1'b0;
			phase_q  <= '0;
			hist_q   <= '0;
		end else if (acc) begin
			if (s_tlast) begin
				pos_q    <= '0;
				locked_q <= 1'b0;
				phase_q  <= '0;
				hist_q   <= '0;
			end else begin
				pos_q    <= bp;
				locked_q <= lock_new;
				phase_q  <= phase_new;
				hist_q   <= {hist_q[tsa_pkg::HIST_LEN-2:0], cur};
			end
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= tsa_pkg::PHASE_LAST)
		else $error("packet phase out of range");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> (pos_q == '0 && !locked_q && hist_q == '0))
		else $error("stream state not cleared at buffer end");

endmodule

/* hdl/tsa_queue.sv */
// Descriptor queue between the front and back ends.
module tsa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsa_pkg::tsa_desc_t push_desc,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output tsa_pkg::tsa_desc_t head_desc
);

	tsa_pkg::tsa_desc_t           mem [tsa_pkg::QUEUE_DEPTH];
	logic [tsa_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tsa_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tsa_pkg::QCNT_W-1:0]   count_q;

	assign full      = (count_q == tsa_pkg::QCNT_W'(tsa_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_desc = mem[rd_ptr_q];

	// Store descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tsa_pkg::QPTR_W'(tsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + tsa_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tsa_pkg::QPTR_W'(tsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + tsa_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tsa_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tsa_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("descriptor queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("descriptor queue underflow");

endmodule

/* hdl/tsa_back.sv */
// Back end: expands descriptors into result words and holds the output register.
module tsa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  tsa_pkg::tsa_desc_t q_head,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	logic [tsa_pkg::NSLOTS-1:0] done_q;
	logic                       m_tvalid_q;
	logic [31:0]                m_tdata_q;
	tsa_pkg::kind_t             m_kind_q;
	logic                       m_tlast_q;

	logic [tsa_pkg::NSLOTS-1:0] rem;
	logic [tsa_pkg::NSLOTS-1:0] rest;
	logic [tsa_pkg::SLOT_W-1:0] sel_idx;
	logic [tsa_pkg::SLOT_W-1:0] pkt_num;
	logic                       load;
	tsa_pkg::kind_t             kind_nx;
	logic [tsa_pkg::POS_W-1:0]  off_nx;
	logic [tsa_pkg::POS_W-1:0]  len_nx;

	assign load  = !q_empty && (!m_tvalid_q || m_tready);
	assign q_pop = load && (rest == '0);

	// Pick the earliest pending slot of the head descriptor
	always_comb begin
		rem     = q_head.slots & ~done_q;
		sel_idx = '0;
		for (int i = tsa_pkg::NSLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel_idx = tsa_pkg::SLOT_W'(i);
			end
		end
		rest    = rem & ~(tsa_pkg::NSLOTS'(1) << sel_idx);
		pkt_num = sel_idx - tsa_pkg::SLOT_W'(tsa_pkg::SLOT_PKT0);

		if (sel_idx == tsa_pkg::SLOT_W'(tsa_pkg::SLOT_HEAD)) begin
			kind_nx = tsa_pkg::KIND_HEAD;
			off_nx  = q_head.lock_start;
			len_nx  = q_head.lock_start;
		end else if (sel_idx < tsa_pkg::SLOT_W'(tsa_pkg::SLOT_CMP)) begin
			// Packets already seen before the lock
			kind_nx = tsa_pkg::KIND_PACKET;
			off_nx  = q_head.lock_sat ? tsa_pkg::POS_MAX :
				q_head.lock_start + tsa_pkg::POS_W'(tsa_pkg::PACKET_LEN * int'(pkt_num));
			len_nx  = tsa_pkg::PKT_LEN_P;
		end else if (sel_idx == tsa_pkg::SLOT_W'(tsa_pkg::SLOT_CMP)) begin
			kind_nx = tsa_pkg::KIND_PACKET;
			off_nx  = q_head.cmp_off;
			len_nx  = tsa_pkg::PKT_LEN_P;
		end else begin
			kind_nx = q_head.end_kind;
			off_nx  = q_head.end_off;
			len_nx  = q_head.end_len;
		end
	end

	// Track slots already sent for the head descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (load) begin
			done_q <= (rest == '0) ? '0 : (q_head.slots & ~rest);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {len_nx, off_nx};
			m_kind_q  <= kind_nx;
			m_tlast_q <= (rest == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_tlast_q;

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (done_q == '0))
		else $error("slot record not cleared after pop");

	a_pick_pending: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (rem != '0))
		else $error("descriptor with no pending slot");

endmodule

/* hdl/ts_packet_sync_aligner.sv */
// Top level: transport-stream sync byte acquisition and packet descriptor output.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata[7:0] data_byte, s_tlast end_of_buffer
// m_*       out  m_tvalid/m_tready    m_tdata offset, length; m_tuser kind; m_tlast last
// cfg_*     in   cfg_we               cfg_wdata[7:0] sync_value
//
// One byte is taken per cycle while the descriptor queue is not full; the history taps
// and counters settle in that cycle. A locking byte yields up to five result words.
// The four-entry descriptor queue decouples intake from output stalls.
// Reset clears stream state and loads the sync byte 0x47; no clearing pass is needed.
module ts_packet_sync_aligner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] offset, [31:16] length
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	tsa_pkg::tsa_desc_t push_desc;
	tsa_pkg::tsa_desc_t head_desc;

	tsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	tsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_desc (head_desc)
	);

	tsa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (head_desc),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* tb/ts_packet_sync_aligner_tb.sv */
// Testbench for the transport-stream sync aligner: directed table, then random buffers.
`timescale 1ns / 1ps

module ts_packet_sync_aligner_tb;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int SETTLE      = 16;
	localparam int N_DIRECTED  = 13;

	// One descriptor as it leaves the block
	typedef struct packed {
		tsa_pkg::kind_t kind;
		logic [15:0]    off;
		logic [15:0]    len;
		logic           last;
	} desc_t;

	// One directed step; the final descriptor is typed in where chk is set
	typedef struct packed {
		logic [7:0]     data;
		logic           eob;
		logic           chk;
		tsa_pkg::kind_t kind;
		logic [15:0]    off;
		logic [15:0]    len;
	} step_row_t;

	localparam step_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b1, tsa_pkg::KIND_NOSYNC, 16'd1, 16'd1},
		'{8'h47, 1'b1, 1'b1, tsa_pkg::KIND_TAIL,   16'd0, 16'd1},
		'{8'hFF, 1'b1, 1'b1, tsa_pkg::KIND_NOSYNC, 16'd1, 16'd1},
		'{8'h47, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'h00, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'h47, 1'b1, 1'b1, tsa_pkg::KIND_TAIL,   16'd0, 16'd3},
		'{8'h46, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'h47, 1'b1, 1'b1, tsa_pkg::KIND_NOSYNC, 16'd2, 16'd2},
		'{8'hAA, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'h55, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'h47, 1'b1, 1'b1, tsa_pkg::KIND_NOSYNC, 16'd3, 16'd3},
		'{8'h47, 1'b0, 1'b0, tsa_pkg::KIND_HEAD,   16'd0, 16'd0},
		'{8'hFF, 1'b1, 1'b1, tsa_pkg::KIND_TAIL,   16'd0, 16'd2}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] offset, [31:16] length
	logic [1:0]  m_tuser;   // [1:0] kind
	logic        m_tlast;

	// Predictor state
	logic [7:0]                   sync_byte;
	logic [15:0]                  byte_pos;
	logic [tsa_pkg::HIST_LEN-1:0] sync_seen;
	logic                         aligned;
	logic [7:0]                   pkt_phase;

	desc_t pending_desc [$];
	bit    failed;
	bit    tx_idle_on;
	bit    rx_idle_on;
	int    cycle_count;

	ts_packet_sync_aligner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	// Clear the per-buffer state; the sync byte survives
	function automatic void restart_buffer();
		byte_pos  = '0;
		sync_seen = '0;
		aligned   = 1'b0;
		pkt_phase = '0;
	endfunction

	// Advance the predictor by one byte, queue its descriptors, return the final one
	function automatic desc_t align_byte(input logic [7:0] b, input logic eob);
		desc_t       res [tsa_pkg::CONFIRM_COUNT+2];
		int          n;
		int          j;
		logic [15:0] pos;
		logic [15:0] start;
		logic [15:0] bp;
		logic        sat;
		logic        hit;
		logic        found;
		logic        ok;
		n     = 0;
		pos   = byte_pos;
		sat   = (pos == tsa_pkg::POS_MAX);
		hit   = (b == sync_byte);
		found = 1'b0;
		start = '0;
		// Look for a sync byte at offset zero or one confirmed at every stride
		if (!aligned) begin
			if (pos == 0 && hit) begin
				found = 1'b1;
			end else begin
				ok = hit && sync_seen[tsa_pkg::HIST_LEN-1];
				for (j = 1; j < tsa_pkg::CONFIRM_COUNT; j++)
					ok = ok && sync_seen[(tsa_pkg::CONFIRM_COUNT - j) * tsa_pkg::PACKET_LEN - 1];
				if (ok && (sat || pos >= tsa_pkg::HIST_LEN)) begin
					found = 1'b1;
					start = sat ? tsa_pkg::POS_MAX : 16'(pos - tsa_pkg::HIST_LEN);
				end
			end
			if (found) begin
				aligned   = 1'b1;
				pkt_phase = '0;
				res[n] = '{tsa_pkg::KIND_HEAD, start, start, 1'b0};
				n++;
				for (j = 0; j < tsa_pkg::CONFIRM_COUNT; j++) begin
					res[n] = '{tsa_pkg::KIND_PACKET,
						sat ? tsa_pkg::POS_MAX : 16'(start + j * tsa_pkg::PACKET_LEN),
						16'(tsa_pkg::PACKET_LEN), 1'b0};
					n++;
				end
			end
		end
		// Report a packet completed by this byte
		if (aligned) begin
			if (pkt_phase >= tsa_pkg::PACKET_LEN - 1) begin
				res[n] = '{tsa_pkg::KIND_PACKET,
					(sat || pos < tsa_pkg::PACKET_LEN - 1) ? tsa_pkg::POS_MAX :
					16'(pos - (tsa_pkg::PACKET_LEN - 1)), 16'(tsa_pkg::PACKET_LEN), 1'b0};
				n++;
				pkt_phase = '0;
			end else begin
				pkt_phase = pkt_phase + 8'd1;
			end
		end
		sync_seen = {sync_seen[tsa_pkg::HIST_LEN-2:0], hit};
		byte_pos  = sat ? tsa_pkg::POS_MAX : pos + 16'd1;
		// Close the buffer with its tail or a no-sync report
		if (eob) begin
			bp = byte_pos;
			if (aligned)
				res[n] = '{tsa_pkg::KIND_TAIL,
					(bp == tsa_pkg::POS_MAX || bp < pkt_phase) ? tsa_pkg::POS_MAX :
					16'(bp - pkt_phase), 16'(pkt_phase), 1'b0};
			else
				res[n] = '{tsa_pkg::KIND_NOSYNC, bp, bp, 1'b0};
			n++;
			restart_buffer();
		end
		if (n == 0)
			return '0;
		res[n-1].last = 1'b1;
		for (j = 0; j < n; j++)
			pending_desc.push_back(res[j]);
		return res[n-1];
	endfunction

	// Offer one word, wait for it to be taken, then predict its descriptors
	task automatic send_byte(input logic [7:0] b, input logic eob, output desc_t fin);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		fin = align_byte(b, eob);
		@(negedge clk);
	endtask

	// Hold the sender until every queued descriptor has come out
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_desc.size() != 0)
			@(negedge clk);
	endtask

	// Write the sync byte while the block is idle
	task automatic set_sync(input logic [7:0] v);
		drain_wait();
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sync_byte = v;
	endtask

	// One buffer of len words, led by the sync byte or by anything else
	task automatic send_buffer(input int len, input bit lead_sync, input int hold_at);
		int         i;
		logic [7:0] b;
		desc_t      fin;
		for (i = 0; i < len; i++) begin
			if (i == hold_at)
				drain_wait();
			b = 8'($urandom_range(0, 255));
			if (i == 0) begin
				if (lead_sync)
					b = sync_byte;
				else if (b == sync_byte)
					b = ~b;
			end else if ($urandom_range(0, 3) == 0) begin
				b = sync_byte;
			end
			send_byte(b, i == len - 1, fin);
		end
	endtask

	// Output side: ready with random stall bursts
	initial begin : drain
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_on && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted word with the oldest expected descriptor
	always @(posedge clk) begin : check_words
		desc_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_desc.size() == 0) begin
				$display("%0t tb: unexpected word, got kind %0d off %0d len %0d last %0b",
					$time, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
				failed = 1'b1;
			end else begin
				want = pending_desc.pop_front();
				if (m_tuser !== want.kind || m_tdata[15:0] !== want.off ||
						m_tdata[31:16] !== want.len || m_tlast !== want.last) begin
					$display("%0t tb: mismatch, expected kind %0d off %0d len %0d last %0b,",
						$time, want.kind, want.off, want.len, want.last);
					$display("%0t tb: got kind %0d off %0d len %0d last %0b",
						$time, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	// Abandon a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] phase_sync [4];
		desc_t      fin;
		int         r;
		int         p;
		int         k;
		bit         calm;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		failed      = 1'b0;
		tx_idle_on  = 1'b1;
		rx_idle_on  = 1'b1;
		cycle_count = 0;
		sync_byte   = tsa_pkg::SYNC_RESET;
		restart_buffer();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed steps at the reset sync byte
		for (r = 0; r < N_DIRECTED; r++) begin
			send_byte(DIRECTED[r].data, DIRECTED[r].eob, fin);
			if (DIRECTED[r].chk && (fin.kind !== DIRECTED[r].kind ||
					fin.off !== DIRECTED[r].off || fin.len !== DIRECTED[r].len)) begin
				$display("%0t tb: directed row %0d, expected kind %0d off %0d len %0d,",
					$time, r, DIRECTED[r].kind, DIRECTED[r].off, DIRECTED[r].len);
				$display("%0t tb: predicted kind %0d off %0d len %0d",
					$time, fin.kind, fin.off, fin.len);
				failed = 1'b1;
			end
		end

		// Random buffers under several sync bytes; the last phase runs without idling
		phase_sync = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h47};
		for (p = 0; p < 4; p++) begin
			calm       = (p == 3);
			tx_idle_on = !calm;
			rx_idle_on = !calm;
			set_sync(phase_sync[p]);
			if (p == 2) begin
				// Lock at offset zero; the last word completes a packet and leaves an empty tail
				send_buffer(tsa_pkg::PACKET_LEN, 1'b1,
					$urandom_range(1, tsa_pkg::PACKET_LEN - 1));
			end else if (calm) begin
				// Back-to-back locks fill the descriptor queue
				for (k = 0; k < 4; k++)
					send_buffer($urandom_range(1, 2), 1'b1, -1);
			end else begin
				for (k = 0; k < 2; k++)
					send_buffer($urandom_range(1, 3), 1'($urandom_range(0, 1)), -1);
			end
		end

		drain_wait();
		repeat (20) @(negedge clk);
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
